FILE: rtl/keypad_date_entry_controller_defines.svh
// Assertion helpers used by the checker file.
`ifndef KEYPAD_DATE_ENTRY_CONTROLLER_DEFINES_SVH
`define KEYPAD_DATE_ENTRY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define KDEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define KDEC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/kdec_pkg.sv
package kdec_pkg;

  // Event codes carried in tuser.
  typedef enum logic [3:0] {
    REQ_DIGIT     = 4'd0,
    REQ_MINUS     = 4'd1,
    REQ_LEFT      = 4'd2,
    REQ_RIGHT     = 4'd3,
    REQ_UP        = 4'd4,
    REQ_DOWN      = 4'd5,
    REQ_OTHER     = 4'd6,
    REQ_FOCUS_IN  = 4'd7,
    REQ_FOCUS_OUT = 4'd8,
    REQ_CLICK     = 4'd9,
    REQ_LOAD      = 4'd10
  } req_e;

  // Field selector codes. Code three is meaningless and selects nothing.
  localparam logic [1:0] FIELD_DAY   = 2'd0;
  localparam logic [1:0] FIELD_MONTH = 2'd1;
  localparam logic [1:0] FIELD_YEAR  = 2'd2;

  localparam logic signed [14:0] REFORM_YEAR    = 15'sd1582;
  localparam logic [3:0]         REFORM_MONTH   = 4'd10;
  localparam logic [14:0]        YEAR_MOST_NEG  = 15'h4000;
  localparam logic signed [14:0] YEAR_MOST_POS  = 15'sd16383;
  localparam logic signed [15:0] YEAR_STEP_MAX  = 16'sd9999;
  localparam logic signed [15:0] YEAR_STEP_MIN  = -16'sd9999;
  localparam logic [17:0]        YEAR_ENTRY_MAX = 18'd9999;
  localparam logic [17:0]        YEAR_ENTRY_FULL = 18'd1000;

  localparam logic signed [14:0] RESET_YEAR  = 15'sd1970;
  localparam logic [3:0]         RESET_MONTH = 4'd10;
  localparam logic [4:0]         RESET_DAY   = 5'd25;

  typedef struct packed {
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [1:0]         field;
    logic               focus;
    logic               first;
  } state_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic [3:0]         digit;
    logic [1:0]         fidx;
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
  } req_t;

  typedef struct packed {
    logic changed;
    logic gained;
    logic lost;
  } flags_t;

  // Divisibility by 25 of a 14-bit value: fold with 128 mod 25 = 3 twice,
  // then the residue is at most 136 and a few compares finish it.
  function automatic logic div25(input logic [13:0] u);
    logic [8:0] r1;
    logic [7:0] r2;
    r1 = 9'(u[13:7]) * 9'd3 + 9'(u[6:0]);
    r2 = 8'(r1[8:7]) * 8'd3 + 8'(r1[6:0]);
    return (r2 == 8'd0) || (r2 == 8'd25) || (r2 == 8'd50) || (r2 == 8'd75) ||
           (r2 == 8'd100) || (r2 == 8'd125);
  endfunction

  // Gregorian rule above the reform year, Julian rule elsewhere.
  function automatic logic is_leap(input logic signed [14:0] y);
    logic by4;
    logic by25;
    by4  = (y[1:0] == 2'b00);
    by25 = div25(y[13:0]);
    if (y > REFORM_YEAR) begin
      return by4 && (!by25 || (y[3:0] == 4'd0));
    end
    return by4;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m,
                                            input logic signed [14:0] y);
    logic [4:0] n;
    case (m)
      4'd2:                             n = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:          n = 5'd30;
      default:                          n = 5'd31;
    endcase
    return n;
  endfunction

  // Limit the day to the month length, then push days inside the
  // October reform gap to its nearest edge.
  function automatic logic [4:0] clamp_day(input logic signed [14:0] y,
                                           input logic [3:0] m,
                                           input logic [4:0] d);
    logic [4:0] dim;
    logic [4:0] c;
    dim = month_days(m, y);
    c   = (d > dim) ? dim : d;
    if ((y == REFORM_YEAR) && (m == REFORM_MONTH) && (c > 5'd4) && (c < 5'd15)) begin
      c = (c < 5'd10) ? 5'd4 : 5'd15;
    end
    return c;
  endfunction

endpackage

FILE: rtl/keypad_date_entry_controller.sv
// Channel  | Dir | tdata fields (lowest bit first)                     | tuser
// ---------+-----+-----------------------------------------------------+-----------
// s_axis   | in  | key_digit, field_index, load_year, load_month,      | req_type
//          |     | load_day                                            |
// m_axis   | out | cur_year, cur_month, cur_day, cur_field, has_focus, | none
//          |     | date_changed, focus_gained, focus_lost              |
//
// Throughput is one event per clock while the result side does not stall. An
// event is held in the input register and is applied to the date state and the
// result register once the result register is empty or being drained.
// Reset puts the date at 1970-10-25 with the year field selected and no focus.
// A stalled result holds the result register; the input register still takes
// one more event, after which s_axis_tready_o drops until the result moves.
module keypad_date_entry_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [3:0] key_digit, [5:4] field_index, [20:6] load_year,
  // [24:21] load_month, [29:25] load_day, [31:30] zero
  input  logic [31:0] s_axis_tdata_i,
  // [3:0] req_type
  input  logic [3:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [14:0] cur_year, [18:15] cur_month, [23:19] cur_day, [25:24] cur_field,
  // [26] has_focus, [27] date_changed, [28] focus_gained, [29] focus_lost,
  // [31:30] zero
  output logic [31:0] m_axis_tdata_o
);

  // Input register: one event waiting to be applied.
  logic             in_valid_q, in_valid_d;
  kdec_pkg::req_t   in_req_q;

  // Date and editor state.
  kdec_pkg::state_t state_q, state_d;

  // Result register.
  logic             out_valid_q, out_valid_d;
  kdec_pkg::state_t out_state_q;
  kdec_pkg::flags_t out_flags_q;
  kdec_pkg::flags_t flags_d;

  logic s_xfer;
  logic advance;

  // An event is applied when the result register is empty or being drained.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  kdec_step u_step (
    .state_i (state_q),
    .req_i   (in_req_q),
    .state_o (state_d),
    .flags_o (flags_d)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q.year  <= kdec_pkg::RESET_YEAR;
      state_q.month <= kdec_pkg::RESET_MONTH;
      state_q.day   <= kdec_pkg::RESET_DAY;
      state_q.field <= kdec_pkg::FIELD_YEAR;
      state_q.focus <= 1'b0;
      state_q.first <= 1'b1;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_req_q.kind  <= s_axis_tuser_i;
      in_req_q.digit <= s_axis_tdata_i[3:0];
      in_req_q.fidx  <= s_axis_tdata_i[5:4];
      in_req_q.year  <= $signed(s_axis_tdata_i[20:6]);
      in_req_q.month <= s_axis_tdata_i[24:21];
      in_req_q.day   <= s_axis_tdata_i[29:25];
    end
    if (advance) begin
      out_state_q <= state_d;
      out_flags_q <= flags_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00,
                            out_flags_q.lost,
                            out_flags_q.gained,
                            out_flags_q.changed,
                            out_state_q.focus,
                            out_state_q.field,
                            out_state_q.day,
                            out_state_q.month,
                            out_state_q.year};

endmodule

FILE: rtl/kdec_step.sv
module kdec_step (
  input  kdec_pkg::state_t state_i,
  input  kdec_pkg::req_t   req_i,
  output kdec_pkg::state_t state_o,
  output kdec_pkg::flags_t flags_o
);

  kdec_pkg::state_t   nxt;
  kdec_pkg::flags_t   flg;
  logic [4:0]         dim;
  logic               oct_gap;
  logic [8:0]         day_mul;
  logic [7:0]         mon_mul;
  logic [17:0]        yr_mul;
  logic signed [15:0] yr_up;
  logic signed [15:0] yr_dn;
  logic [4:0]         mon_up;
  logic [5:0]         day_up;
  logic [4:0]         day_v;
  logic               step_up;

  assign dim     = kdec_pkg::month_days(state_i.month, state_i.year);
  assign oct_gap = (state_i.year == kdec_pkg::REFORM_YEAR) &&
                   (state_i.month == kdec_pkg::REFORM_MONTH);
  assign day_mul = 9'(state_i.day) * 9'd10 + 9'(req_i.digit);
  assign mon_mul = 8'(state_i.month) * 8'd10 + 8'(req_i.digit);
  assign yr_mul  = 18'(state_i.year[13:0]) * 18'd10 + 18'(req_i.digit);
  assign yr_up   = {state_i.year[14], state_i.year} + 16'sd1;
  assign yr_dn   = {state_i.year[14], state_i.year} - 16'sd1;
  assign mon_up  = 5'(state_i.month) + 5'd1;
  assign day_up  = 6'(state_i.day) + 6'd1;
  assign step_up = (req_i.kind == kdec_pkg::REQ_UP);

  always_comb begin
    nxt   = state_i;
    flg   = '0;
    day_v = state_i.day;
    case (kdec_pkg::req_e'(req_i.kind))
      kdec_pkg::REQ_DIGIT: begin
        if (state_i.focus) begin
          flg.changed = 1'b1;
          if (state_i.first) begin
            if (req_i.digit != 4'd0) begin
              case (state_i.field)
                kdec_pkg::FIELD_DAY:   nxt.day   = 5'(req_i.digit);
                kdec_pkg::FIELD_MONTH: nxt.month = req_i.digit;
                kdec_pkg::FIELD_YEAR:  nxt.year  = 15'(req_i.digit);
                default: ;
              endcase
            end
            nxt.first = 1'b0;
          end else begin
            case (state_i.field)
              kdec_pkg::FIELD_DAY: begin
                if (day_mul >= 9'd10) nxt.first = 1'b1;
                nxt.day = (day_mul > 9'(dim)) ? 5'd1 : day_mul[4:0];
              end
              kdec_pkg::FIELD_MONTH: begin
                if (mon_mul > 8'd1) nxt.first = 1'b1;
                nxt.month = (mon_mul > 8'd12) ? 4'd1 : mon_mul[3:0];
              end
              kdec_pkg::FIELD_YEAR: begin
                if (state_i.year[14]) begin
                  nxt.first = 1'b1;
                end else begin
                  if (yr_mul >= kdec_pkg::YEAR_ENTRY_FULL) nxt.first = 1'b1;
                  if (yr_mul <= kdec_pkg::YEAR_ENTRY_MAX) nxt.year = $signed(yr_mul[14:0]);
                end
              end
              default: ;
            endcase
          end
          nxt.day = kdec_pkg::clamp_day(nxt.year, nxt.month, nxt.day);
        end
      end
      kdec_pkg::REQ_MINUS: begin
        if (state_i.focus && (state_i.field == kdec_pkg::FIELD_YEAR)) begin
          nxt.year = (state_i.year == kdec_pkg::YEAR_MOST_NEG) ?
                     kdec_pkg::YEAR_MOST_POS : -state_i.year;
          nxt.day  = kdec_pkg::clamp_day(nxt.year, nxt.month, nxt.day);
          flg.changed = 1'b1;
        end
      end
      kdec_pkg::REQ_LEFT: begin
        if (state_i.focus) begin
          nxt.first = 1'b1;
          nxt.field = (state_i.field == kdec_pkg::FIELD_DAY) ?
                      kdec_pkg::FIELD_YEAR : state_i.field - 2'd1;
        end
      end
      kdec_pkg::REQ_RIGHT: begin
        if (state_i.focus) begin
          nxt.first = 1'b1;
          nxt.field = (state_i.field >= kdec_pkg::FIELD_YEAR) ?
                      kdec_pkg::FIELD_DAY : state_i.field + 2'd1;
        end
      end
      kdec_pkg::REQ_UP, kdec_pkg::REQ_DOWN: begin
        if (state_i.focus) begin
          nxt.first   = 1'b1;
          flg.changed = 1'b1;
          case (state_i.field)
            kdec_pkg::FIELD_YEAR: begin
              if (step_up) begin
                nxt.year = (yr_up > kdec_pkg::YEAR_STEP_MAX) ?
                           kdec_pkg::YEAR_STEP_MAX[14:0] : yr_up[14:0];
              end else begin
                nxt.year = (yr_dn < kdec_pkg::YEAR_STEP_MIN) ?
                           kdec_pkg::YEAR_STEP_MIN[14:0] : yr_dn[14:0];
              end
              nxt.day = kdec_pkg::clamp_day(nxt.year, nxt.month, nxt.day);
            end
            kdec_pkg::FIELD_MONTH: begin
              if (step_up) begin
                nxt.month = (mon_up > 5'd12) ? 4'd1 : mon_up[3:0];
              end else begin
                nxt.month = (state_i.month < 4'd2) ? 4'd12 : state_i.month - 4'd1;
              end
              nxt.day = kdec_pkg::clamp_day(nxt.year, nxt.month, nxt.day);
            end
            kdec_pkg::FIELD_DAY: begin
              if (step_up) begin
                day_v = (day_up > 6'(dim)) ? 5'd1 : day_up[4:0];
                if (oct_gap && (day_v == 5'd5)) day_v = 5'd15;
              end else begin
                day_v = (state_i.day < 5'd2) ? dim : state_i.day - 5'd1;
                if (oct_gap && (day_v == 5'd14)) day_v = 5'd4;
              end
              nxt.day = day_v;
            end
            default: ;
          endcase
        end
      end
      kdec_pkg::REQ_OTHER: begin
        if (state_i.focus) nxt.first = 1'b1;
      end
      kdec_pkg::REQ_FOCUS_IN: begin
        nxt.focus  = 1'b1;
        nxt.first  = 1'b1;
        flg.gained = !state_i.focus;
      end
      kdec_pkg::REQ_FOCUS_OUT: begin
        nxt.focus = 1'b0;
        flg.lost  = state_i.focus;
      end
      kdec_pkg::REQ_CLICK: begin
        if (req_i.fidx <= kdec_pkg::FIELD_YEAR) nxt.field = req_i.fidx;
        if (!state_i.focus) begin
          nxt.focus  = 1'b1;
          nxt.first  = 1'b1;
          flg.gained = 1'b1;
        end
      end
      kdec_pkg::REQ_LOAD: begin
        nxt.year  = req_i.year;
        nxt.month = req_i.month;
        nxt.day   = req_i.day;
      end
      default: ;
    endcase
  end

  assign state_o = nxt;
  assign flags_o = flg;

endmodule

FILE: rtl/kdec_checker.sv
`include "keypad_date_entry_controller_defines.svh"

module kdec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_i,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_i
);

  logic gained;
  logic lost;
  logic focus;

  assign focus  = m_axis_tdata_i[26];
  assign gained = m_axis_tdata_i[28];
  assign lost   = m_axis_tdata_i[29];

  `KDEC_ASSERT_IMP(a_gain_has_focus, m_axis_tvalid_i && gained, focus, "focus gained without focus")
  `KDEC_ASSERT_IMP(a_lost_no_focus, m_axis_tvalid_i && lost, !focus, "focus lost while focused")
  `KDEC_ASSERT_IMP(a_gain_lost_excl, m_axis_tvalid_i, !(gained && lost), "focus gained and lost")
  `KDEC_ASSERT_IMP(a_stall_only_full, !s_axis_tready_i, m_axis_tvalid_i && !m_axis_tready_i, "input stalled while result side free")
  `KDEC_ASSERT_NXT(a_result_holds, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i), "stalled result changed")

endmodule

bind keypad_date_entry_controller kdec_checker u_kdec_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

FILE: tb/sv/keypad_date_entry_controller_tb.sv
`timescale 1ns / 100ps

module keypad_date_entry_controller_tb;

  localparam int REFORM_YR   = 1582;
  localparam int REFORM_MON  = 10;
  localparam int YEAR_LIMIT  = 9999;
  localparam int CYCLE_LIMIT = 400000;

  // Request code outside the defined set and the field code that selects nothing.
  localparam logic [3:0] REQ_UNUSED = 4'd15;
  localparam logic [1:0] FIELD_NONE = 2'd3;

  typedef struct packed {
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [1:0]         field;
    logic               focus;
    logic               changed;
    logic               gained;
    logic               lost;
  } date_result_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready_o;
  // [3:0] key_digit, [5:4] field_index, [20:6] load_year,
  // [24:21] load_month, [29:25] load_day, [31:30] zero
  logic [31:0] s_axis_tdata = '0;
  // [3:0] req_type
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready = 1'b0;
  // [14:0] cur_year, [18:15] cur_month, [23:19] cur_day, [25:24] cur_field,
  // [26] has_focus, [27] date_changed, [28] focus_gained, [29] focus_lost
  logic [31:0] m_axis_tdata_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Predicted editor state.
  int          ed_year;
  int unsigned ed_month;
  int unsigned ed_day;
  logic [1:0]  ed_field;
  bit          ed_focus;
  bit          ed_first_digit;

  date_result_t expected_dates[$];
  date_result_t want_date;
  date_result_t got_date;

  keypad_date_entry_controller u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Calendar prediction
  // ---------------------------------------------------------------------------

  // Gregorian leap rule after the reform year, Julian otherwise. The low two
  // bits of the two's-complement year decide divisibility by four, which is
  // also right for negative years.
  function automatic int unsigned days_in_month(input int unsigned m, input int y);
    bit leap_yr;
    leap_yr = ((y & 3) == 0);
    if (y > REFORM_YR) leap_yr = leap_yr && (((y % 100) != 0) || ((y % 400) == 0));
    if (m == 2) return leap_yr ? 29 : 28;
    if (m < 1 || m > 12) return 31;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic bit in_reform_october();
    return (ed_year == REFORM_YR) && (ed_month == REFORM_MON);
  endfunction

  // Limit the day to the month, then move a day inside the October gap to
  // the nearer edge of the gap.
  function automatic void clamp_edit_date();
    int unsigned dim;
    dim = days_in_month(ed_month, ed_year);
    if (ed_day > dim) ed_day = dim;
    if (in_reform_october() && ed_day > 4 && ed_day < 15) ed_day = (ed_day < 10) ? 4 : 15;
  endfunction

  function automatic void enter_digit(input int unsigned d);
    int unsigned v;
    int          yv;
    if (ed_first_digit) begin
      // A leading zero leaves the field alone but arms the shift-in path.
      if (d != 0) begin
        if (ed_field == kdec_pkg::FIELD_DAY) ed_day = d & 31;
        else if (ed_field == kdec_pkg::FIELD_MONTH) ed_month = d & 15;
        else if (ed_field == kdec_pkg::FIELD_YEAR) ed_year = int'(d);
      end
      ed_first_digit = 1'b0;
    end else if (ed_field == kdec_pkg::FIELD_DAY) begin
      v = ed_day * 10 + d;
      if (v >= 10) ed_first_digit = 1'b1;
      if (v > days_in_month(ed_month, ed_year)) v = 1;
      ed_day = v & 31;
    end else if (ed_field == kdec_pkg::FIELD_MONTH) begin
      v = ed_month * 10 + d;
      if (v > 1) ed_first_digit = 1'b1;
      if (v > 12) v = 1;
      ed_month = v;
    end else if (ed_field == kdec_pkg::FIELD_YEAR) begin
      if (ed_year < 0) begin
        ed_first_digit = 1'b1;
      end else begin
        yv = ed_year * 10 + int'(d);
        if (yv >= 1000) ed_first_digit = 1'b1;
        if (yv <= YEAR_LIMIT) ed_year = yv;
      end
    end
    clamp_edit_date();
  endfunction

  function automatic void step_selected(input bit up);
    int          yv;
    int unsigned dim;
    int unsigned v;
    if (ed_field == kdec_pkg::FIELD_YEAR) begin
      yv = ed_year + (up ? 1 : -1);
      if (up && yv > YEAR_LIMIT) yv = YEAR_LIMIT;
      if (!up && yv < -YEAR_LIMIT) yv = -YEAR_LIMIT;
      ed_year = yv;
      clamp_edit_date();
    end else if (ed_field == kdec_pkg::FIELD_MONTH) begin
      if (up) begin
        ed_month = ed_month + 1;
        if (ed_month > 12) ed_month = 1;
      end else begin
        ed_month = (ed_month < 2) ? 12 : ed_month - 1;
      end
      clamp_edit_date();
    end else if (ed_field == kdec_pkg::FIELD_DAY) begin
      // Day stepping wraps inside the month and jumps over the reform gap.
      dim = days_in_month(ed_month, ed_year);
      if (up) begin
        v = ed_day + 1;
        if (v > dim) v = 1;
        if (in_reform_october() && v == 5) v = 15;
      end else begin
        v = (ed_day < 2) ? dim : ed_day - 1;
        if (in_reform_october() && v == 14) v = 4;
      end
      ed_day = v;
    end
  endfunction

  function automatic void reset_editor_model();
    ed_year        = 1970;
    ed_month       = 10;
    ed_day         = 25;
    ed_field       = kdec_pkg::FIELD_YEAR;
    ed_focus       = 1'b0;
    ed_first_digit = 1'b1;
  endfunction

  // Applies one event to the predicted state and returns the result it gives.
  function automatic date_result_t apply_event(input kdec_pkg::req_t ev);
    date_result_t r;
    bit           chg;
    bit           gain;
    bit           lose;
    chg  = 1'b0;
    gain = 1'b0;
    lose = 1'b0;
    case (ev.kind)
      kdec_pkg::REQ_DIGIT, kdec_pkg::REQ_MINUS, kdec_pkg::REQ_LEFT, kdec_pkg::REQ_RIGHT,
      kdec_pkg::REQ_UP, kdec_pkg::REQ_DOWN, kdec_pkg::REQ_OTHER: begin
        // Keys do nothing at all while the editor has no focus.
        if (ed_focus) begin
          if (ev.kind == kdec_pkg::REQ_DIGIT) begin
            enter_digit(int'(ev.digit));
            chg = 1'b1;
          end else if (ev.kind == kdec_pkg::REQ_MINUS) begin
            if (ed_field == kdec_pkg::FIELD_YEAR) begin
              ed_year = (ed_year == -16384) ? 16383 : -ed_year;
              clamp_edit_date();
              chg = 1'b1;
            end
          end else begin
            ed_first_digit = 1'b1;
            if (ev.kind == kdec_pkg::REQ_LEFT) begin
              ed_field = (ed_field == kdec_pkg::FIELD_DAY) ?
                         kdec_pkg::FIELD_YEAR : ed_field - 2'd1;
            end else if (ev.kind == kdec_pkg::REQ_RIGHT) begin
              ed_field = (ed_field >= kdec_pkg::FIELD_YEAR) ?
                         kdec_pkg::FIELD_DAY : ed_field + 2'd1;
            end else if (ev.kind == kdec_pkg::REQ_UP || ev.kind == kdec_pkg::REQ_DOWN) begin
              step_selected(ev.kind == kdec_pkg::REQ_UP);
              chg = 1'b1;
            end
          end
        end
      end
      kdec_pkg::REQ_FOCUS_IN: begin
        if (!ed_focus) begin
          ed_focus = 1'b1;
          gain     = 1'b1;
        end
        ed_first_digit = 1'b1;
      end
      kdec_pkg::REQ_FOCUS_OUT: begin
        if (ed_focus) begin
          ed_focus = 1'b0;
          lose     = 1'b1;
        end
      end
      kdec_pkg::REQ_CLICK: begin
        if (ev.fidx <= kdec_pkg::FIELD_YEAR) ed_field = ev.fidx;
        if (!ed_focus) begin
          ed_focus       = 1'b1;
          gain           = 1'b1;
          ed_first_digit = 1'b1;
        end
      end
      kdec_pkg::REQ_LOAD: begin
        ed_year  = int'($signed(ev.year));
        ed_month = int'(ev.month);
        ed_day   = int'(ev.day);
      end
      default: ;
    endcase
    r.year    = ed_year[14:0];
    r.month   = ed_month[3:0];
    r.day     = ed_day[4:0];
    r.field   = ed_field;
    r.focus   = ed_focus;
    r.changed = chg;
    r.gained  = gain;
    r.lost    = lose;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Event transfers
  // ---------------------------------------------------------------------------

  function automatic kdec_pkg::req_t make_event(input logic [3:0] kind,
                                                input logic [3:0] digit,
                                                input logic [1:0] fidx, input int year,
                                                input int month, input int day);
    kdec_pkg::req_t ev;
    ev.kind  = kind;
    ev.digit = digit;
    ev.fidx  = fidx;
    ev.year  = year[14:0];
    ev.month = month[3:0];
    ev.day   = day[4:0];
    return ev;
  endfunction

  // Offers one event and returns at the edge of its transfer. tvalid stays
  // high afterwards, so back-to-back events keep it high without a gap.
  task automatic send_event(input kdec_pkg::req_t ev);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, ev.day, ev.month, ev.year, ev.fidx, ev.digit};
    s_axis_tuser  <= ev.kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_dates.push_back(apply_event(ev));
  endtask

  task automatic send_key(input logic [3:0] kind, input logic [3:0] digit);
    send_event(make_event(kind, digit, kdec_pkg::FIELD_DAY, 0, 1, 1));
  endtask

  task automatic send_click(input logic [1:0] fidx);
    send_event(make_event(kdec_pkg::REQ_CLICK, 4'd0, fidx, 0, 1, 1));
  endtask

  task automatic send_load(input int year, input int month, input int day);
    send_event(make_event(kdec_pkg::REQ_LOAD, 4'd0, kdec_pkg::FIELD_DAY, year, month, day));
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Focus handling and keys that must be ignored.
  task automatic test_focus_rules();
    send_key(kdec_pkg::REQ_UP, 4'd0);          // no focus yet, nothing happens
    send_key(kdec_pkg::REQ_FOCUS_OUT, 4'd0);   // losing focus that is not held
    send_click(FIELD_NONE);                    // gains focus, field is kept
    send_key(kdec_pkg::REQ_FOCUS_IN, 4'd0);    // focus already held, no notification
    send_key(kdec_pkg::REQ_OTHER, 4'd0);
    send_key(REQ_UNUSED, 4'd0);                // unused request code
    send_key(kdec_pkg::REQ_FOCUS_OUT, 4'd0);
    send_click(kdec_pkg::FIELD_MONTH);         // click without focus gains it
  endtask

  // Digit entry on the year and day fields, including rejected values.
  task automatic test_digit_entry();
    send_click(kdec_pkg::FIELD_YEAR);
    send_key(kdec_pkg::REQ_DIGIT, 4'd0);       // leading zero keeps 1970
    send_key(kdec_pkg::REQ_DIGIT, 4'd5);       // 19705 is too large, year kept
    send_key(kdec_pkg::REQ_MINUS, 4'd0);
    send_key(kdec_pkg::REQ_DIGIT, 4'd0);
    send_key(kdec_pkg::REQ_DIGIT, 4'd7);       // negative year refuses shifted digits
    send_click(kdec_pkg::FIELD_DAY);
    send_key(kdec_pkg::REQ_DIGIT, 4'd15);      // digit code above nine goes in as is
    send_key(kdec_pkg::REQ_DIGIT, 4'd3);       // 153 is past the month, day wraps to one
  endtask

  // Year extremes: the one value that cannot be negated and both saturations.
  task automatic test_year_limits();
    send_load(-16384, 15, 0);
    send_click(kdec_pkg::FIELD_YEAR);
    send_key(kdec_pkg::REQ_MINUS, 4'd0);
    send_key(kdec_pkg::REQ_UP, 4'd0);
    send_load(-9999, 2, 29);
    send_key(kdec_pkg::REQ_DOWN, 4'd0);
  endtask

  // The ten days dropped in October of the reform year.
  task automatic test_reform_gap();
    send_load(REFORM_YR, REFORM_MON, 4);
    send_click(kdec_pkg::FIELD_DAY);
    send_key(kdec_pkg::REQ_UP, 4'd0);
    send_key(kdec_pkg::REQ_DOWN, 4'd0);
    send_load(REFORM_YR, 11, 9);
    send_click(kdec_pkg::FIELD_MONTH);
    send_key(kdec_pkg::REQ_DOWN, 4'd0);        // lands inside the gap and is clamped
  endtask

  // ---------------------------------------------------------------------------
  // Random edits
  // ---------------------------------------------------------------------------

  function automatic int pick_load_year();
    int y;
    case ($urandom_range(0, 7))
      0: y = int'($urandom_range(0, 32767)) - 16384;
      1: y = REFORM_YR;
      2: y = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(9990, 9999));
      3: begin
        case ($urandom_range(0, 7))
          0: y = 1500;
          1: y = 1600;
          2: y = 1700;
          3: y = 1900;
          4: y = 2000;
          5: y = 0;
          6: y = -4;
          default: y = -100;
        endcase
      end
      4: y = int'($urandom_range(0, 20));
      5: y = int'($urandom_range(0, 19998)) - YEAR_LIMIT;
      6: y = int'($urandom_range(1580, 1584));
      default: y = int'($urandom_range(1000, 2999));
    endcase
    return y;
  endfunction

  // Mostly key traffic while focused, with loads seeding interesting dates.
  function automatic kdec_pkg::req_t random_edit_event();
    int          w;
    int          m;
    int          d;
    logic [3:0]  kind;
    logic [3:0]  digit;
    w     = $urandom_range(0, 99);
    digit = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 9));
    if (w < 28)      kind = kdec_pkg::REQ_DIGIT;
    else if (w < 33) kind = kdec_pkg::REQ_MINUS;
    else if (w < 41) kind = $urandom_range(0, 1) ? kdec_pkg::REQ_LEFT : kdec_pkg::REQ_RIGHT;
    else if (w < 63) kind = $urandom_range(0, 1) ? kdec_pkg::REQ_UP : kdec_pkg::REQ_DOWN;
    else if (w < 65) kind = kdec_pkg::REQ_OTHER;
    else if (w < 67) kind = 4'($urandom_range(11, 15));
    else if (w < 72) kind = kdec_pkg::REQ_FOCUS_IN;
    else if (w < 75) kind = kdec_pkg::REQ_FOCUS_OUT;
    else if (w < 84) kind = kdec_pkg::REQ_CLICK;
    else             kind = kdec_pkg::REQ_LOAD;
    if ($urandom_range(0, 9) == 0) begin
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
    end else begin
      m = $urandom_range(0, 2) == 0 ? 10 : $urandom_range(1, 12);
      d = $urandom_range(1, 31);
    end
    return make_event(kind, digit, 2'($urandom_range(0, 3)), pick_load_year(), m, d);
  endfunction

  task automatic test_random_edits(input int count);
    repeat (count) send_event(random_edit_event());
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic report_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      mismatch_count++;
    end
  endtask

  // Every result transfer is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      got_date.year    = m_axis_tdata_o[14:0];
      got_date.month   = m_axis_tdata_o[18:15];
      got_date.day     = m_axis_tdata_o[23:19];
      got_date.field   = m_axis_tdata_o[25:24];
      got_date.focus   = m_axis_tdata_o[26];
      got_date.changed = m_axis_tdata_o[27];
      got_date.gained  = m_axis_tdata_o[28];
      got_date.lost    = m_axis_tdata_o[29];
      if (expected_dates.size() == 0) begin
        $error("result transfer with no event waiting: %h", m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want_date = expected_dates.pop_front();
        report_field("cur_year", int'(want_date.year), int'(got_date.year));
        report_field("cur_month", int'(want_date.month), int'(got_date.month));
        report_field("cur_day", int'(want_date.day), int'(got_date.day));
        report_field("cur_field", int'(want_date.field), int'(got_date.field));
        report_field("has_focus", int'(want_date.focus), int'(got_date.focus));
        report_field("date_changed", int'(want_date.changed), int'(got_date.changed));
        report_field("focus_gained", int'(want_date.gained), int'(got_date.gained));
        report_field("focus_lost", int'(want_date.lost), int'(got_date.lost));
      end
    end
  end

  // Watchdog for a stuck handshake.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_editor_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender pauses now and then, receiver stalls about half the time.
    send_idle_pct = 10;
    recv_idle_pct = 47;
    test_focus_rules();
    test_digit_entry();
    test_year_limits();
    test_reform_gap();
    test_random_edits(700);

    // Swap the pressure: sparse events, an eager receiver.
    send_idle_pct = 47;
    recv_idle_pct = 10;
    test_random_edits(700);

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_edits(650);

    s_axis_tvalid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: keypad_date_entry_controller.f
+incdir+rtl
rtl/kdec_pkg.sv
rtl/kdec_step.sv
rtl/keypad_date_entry_controller.sv
rtl/kdec_checker.sv
tb/sv/keypad_date_entry_controller_tb.sv
